>>> rtl/sbpr_pkg.sv
package sbpr_pkg;

   // Sync byte that opens every packet
   localparam logic [7:0] SYNC_BYTE = 8'hFF;

   // Fixed packet positions and limits
   localparam int unsigned HDR_BYTES = 4;
   localparam logic [8:0] MAX_INDEX = 9'd259;

   // Register indexes on the csr port
   localparam logic [1:0] REG_MAX_ID = 2'd0;
   localparam logic [1:0] REG_MAX_LENGTH = 2'd1;
   localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd2;

   // Reset values of the registers
   localparam logic [7:0] MAX_ID_RESET = 8'd253;
   localparam logic [7:0] MAX_LENGTH_RESET = 8'd64;
   localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

   // Input word kinds
   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   typedef enum logic [2:0] {
      PH_SYNC1 = 3'd0,
      PH_SYNC2 = 3'd1,
      PH_ID = 3'd2,
      PH_LEN = 3'd3,
      PH_PAYLOAD = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      ST_PROGRESS = 3'd0,
      ST_COMPLETE = 3'd1,
      ST_BAD_SYNC = 3'd2,
      ST_BAD_ID = 3'd3,
      ST_BAD_LEN = 3'd4,
      ST_TIMEOUT = 3'd5
   } status_type;

   typedef struct packed {
      logic [7:0] max_id;
      logic [7:0] max_length;
      logic [15:0] timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic valid;
      logic [7:0] value;
      logic [8:0] index;
      status_type status;
      logic last;
   } result_type;

endpackage

>>> rtl/servo_bus_packet_receiver.sv
// Servo bus status packet receiver.
// A word taken on req_ passes one input register, then the parser logic into the output
// register, before its result shows on rsp_. Throughput: one word per cycle while no
// result waits on rsp_tready; tick words give no result unless they time out a packet.
// Reset: the parser returns to sync hunt, both registers empty, csr values back
// to max_id 253, max_length 64, timeout_ticks 1000.
module servo_bus_packet_receiver (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   output logic req_tready,
   input logic [7:0] req_tdata, // [7:0] rx_byte
   input logic req_tuser, // [0] kind
   output logic rsp_tvalid,
   input logic rsp_tready,
   output logic [23:0] rsp_tdata, // [7:0] byte_value, [16:8] byte_index, [23:17] zero
   output logic [2:0] rsp_tuser, // [2:0] status
   output logic rsp_tlast, // last
   input logic csr_valid,
   output logic csr_ready,
   input logic [1:0] csr_index,
   input logic [15:0] csr_data
);
   import sbpr_pkg::*;

   cfg_type cfg_ff;
   logic in_valid_ff;
   logic in_kind_ff;
   logic [7:0] in_byte_ff;
   logic out_valid_ff, out_valid_in;
   result_type out_ff;
   result_type res;
   logic advance;

   // Move the held word on when the output register is free or draining
   assign advance = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_id <= MAX_ID_RESET;
         cfg_ff.max_length <= MAX_LENGTH_RESET;
         cfg_ff.timeout_ticks <= TIMEOUT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_MAX_ID: cfg_ff.max_id <= csr_data[7:0];
            REG_MAX_LENGTH: cfg_ff.max_length <= csr_data[7:0];
            REG_TIMEOUT_TICKS: cfg_ff.timeout_ticks <= csr_data;
            default: ;
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_kind_ff <= req_tuser;
         in_byte_ff <= req_tdata;
      end
   end

   sbpr_parser u_parser (
      .clock(clock),
      .reset(reset),
      .step(advance),
      .kind(in_kind_ff),
      .rx_byte(in_byte_ff),
      .cfg(cfg_ff),
      .res(res)
   );

   // Output register: load on advance, clear once taken
   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = res.valid;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res.valid) begin
         out_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {7'd0, out_ff.index, out_ff.value};
   assign rsp_tuser = out_ff.status;
   assign rsp_tlast = out_ff.last;

   // Checks on the result words
   a_last_ends_packet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser != ST_PROGRESS)))
      else $error("last flag disagrees with status");

   a_timeout_zero_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == ST_TIMEOUT) |-> (rsp_tdata[7:0] == 8'd0))
      else $error("timeout word carries a byte value");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[16:8] <= MAX_INDEX))
      else $error("byte index beyond longest packet");

   a_sync_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == ST_BAD_SYNC) |-> (rsp_tdata[16:8] <= 9'd1))
      else $error("bad sync past the sync bytes");

endmodule

>>> rtl/sbpr_parser.sv
module sbpr_parser (
   input logic clock,
   input logic reset,
   input logic step,
   input logic kind,
   input logic [7:0] rx_byte,
   input sbpr_pkg::cfg_type cfg,
   output sbpr_pkg::result_type res
);
   import sbpr_pkg::*;

   phase_type phase_ff, phase_in;
   logic [8:0] byte_count_ff, byte_count_in;
   logic [7:0] payload_length_ff, payload_length_in;
   logic [15:0] idle_count_ff, idle_count_in;

   logic [15:0] limit;
   logic [15:0] idle_next;
   logic [9:0] end_pos;
   logic [9:0] next_pos;

   // Effective tick limit and saturating idle count
   assign limit = (cfg.timeout_ticks == 16'd0) ? 16'd1 : cfg.timeout_ticks;
   assign idle_next = (idle_count_ff == 16'hFFFF) ? idle_count_ff : idle_count_ff + 16'd1;
   assign end_pos = 10'(HDR_BYTES) + {2'b00, payload_length_ff};
   assign next_pos = {1'b0, byte_count_ff} + 10'd1;

   // Next state and result for the word in hand
   always_comb begin
      phase_in = phase_ff;
      byte_count_in = byte_count_ff;
      payload_length_in = payload_length_ff;
      idle_count_in = idle_count_ff;
      res.valid = 1'b0;
      res.value = rx_byte;
      res.index = byte_count_ff;
      res.status = ST_PROGRESS;
      res.last = 1'b0;

      if (kind == KIND_TICK) begin
         res.value = 8'd0;
         case (phase_ff)
            PH_SYNC2, PH_ID, PH_LEN, PH_PAYLOAD: begin
               idle_count_in = idle_next;
               if (idle_next >= limit) begin
                  res.valid = 1'b1;
                  res.status = ST_TIMEOUT;
                  res.last = 1'b1;
                  phase_in = PH_SYNC1;
                  byte_count_in = 9'd0;
                  payload_length_in = 8'd0;
                  idle_count_in = 16'd0;
               end
            end
            default: begin
               // waiting for sync: ticks are ignored
               phase_in = PH_SYNC1;
               byte_count_in = 9'd0;
               payload_length_in = 8'd0;
               idle_count_in = 16'd0;
            end
         endcase
      end else begin
         res.valid = 1'b1;
         idle_count_in = 16'd0;
         byte_count_in = next_pos[8:0];
         case (phase_ff)
            PH_SYNC2: begin
               if (rx_byte != SYNC_BYTE) begin
                  res.status = ST_BAD_SYNC;
               end else begin
                  phase_in = PH_ID;
               end
            end
            PH_ID: begin
               if (rx_byte > cfg.max_id) begin
                  res.status = ST_BAD_ID;
               end else begin
                  phase_in = PH_LEN;
               end
            end
            PH_LEN: begin
               if (rx_byte > cfg.max_length) begin
                  res.status = ST_BAD_LEN;
               end else if (rx_byte == 8'd0) begin
                  res.status = ST_COMPLETE;
               end else begin
                  payload_length_in = rx_byte;
                  phase_in = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               if (next_pos >= end_pos) begin
                  res.status = ST_COMPLETE;
               end
            end
            default: begin
               // first sync byte opens a packet at position zero
               res.index = 9'd0;
               byte_count_in = 9'd1;
               if (rx_byte != SYNC_BYTE) begin
                  res.status = ST_BAD_SYNC;
               end else begin
                  phase_in = PH_SYNC2;
               end
            end
         endcase
         // drop back to sync hunt when the packet ends
         if (res.status != ST_PROGRESS) begin
            res.last = 1'b1;
            phase_in = PH_SYNC1;
            byte_count_in = 9'd0;
            payload_length_in = 8'd0;
         end
      end
   end

   // Hold parser state, advance on each word
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SYNC1;
         byte_count_ff <= 9'd0;
         payload_length_ff <= 8'd0;
         idle_count_ff <= 16'd0;
      end else if (step) begin
         phase_ff <= phase_in;
         byte_count_ff <= byte_count_in;
         payload_length_ff <= payload_length_in;
         idle_count_ff <= idle_count_in;
      end
   end

endmodule
